### rtl/stoi_pkg.sv
// ----------------------------------------------------------------------------
// stoi_pkg
// Types, constants and helpers shared by the string-to-integer parser.
// ----------------------------------------------------------------------------
package stoi_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int BASE_BITS       = 6;
  localparam int MAX_BASE        = 36;
  localparam int DEC_BASE        = 10;
  localparam int HEX_BASE        = 16;
  localparam int OCT_BASE        = 8;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;

  localparam logic [6:0]  NOT_DIGIT = 7'd99;
  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_OVF
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_BASE,
    ST_RANGE
  } status_e;

  typedef struct packed {
    logic [7:0] character;
    logic       first;
  } stoi_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [15:0]        end_offset;
    status_e            status;
  } stoi_out_t;

  typedef struct packed {
    phase_e                 phase;
    logic [63:0]            magnitude;
    logic                   negative;
    logic [BASE_BITS-1:0]   active_base;
  } stoi_state_t;

  // digit value of a character, letters of either case from 10 up
  function automatic logic [6:0] digit_of(logic [7:0] c);
    logic [6:0] d;
    d = NOT_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = 7'(c - CH_ZERO);
    end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
      d = 7'(c - CH_A_LO + 8'd10);
    end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
      d = 7'(c - CH_A_UP + 8'd10);
    end
    return d;
  endfunction

endpackage

### rtl/stoi_step.sv
// ----------------------------------------------------------------------------
// stoi_step
// Next-state and result logic for one character: base check, whitespace, sign,
// prefix, digit accumulation with overflow detection.
// ----------------------------------------------------------------------------
module stoi_step #(
  parameter int OFFSET_BITS = stoi_pkg::OFFSET_BITS_DEF
) (
  input  stoi_pkg::stoi_in_t                   beat_i,
  input  logic [stoi_pkg::BASE_BITS-1:0]       number_base_i,
  input  stoi_pkg::stoi_state_t                state_i,
  input  logic [OFFSET_BITS-1:0]               pos_i,
  output stoi_pkg::stoi_state_t                state_o,
  output logic [OFFSET_BITS-1:0]               pos_o,
  output logic                                 emit_o,
  output stoi_pkg::stoi_out_t                  result_o
);
  import stoi_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

  logic [7:0]             c;
  logic                   go;
  logic [OFFSET_BITS-1:0] idx;
  phase_e                 ph;
  logic [63:0]            mag;
  logic                   neg;
  logic [BASE_BITS-1:0]   ab;
  logic [6:0]             d;
  logic [69:0]            prod;
  logic [69:0]            sum;
  logic [63:0]            limit;

  always_comb begin
    c        = beat_i.character;
    go       = 1'b1;
    idx      = '0;
    ph       = state_i.phase;
    mag      = state_i.magnitude;
    neg      = state_i.negative;
    ab       = state_i.active_base;
    pos_o    = pos_i;
    emit_o   = 1'b0;
    result_o = '{value: '0, end_offset: '0, status: ST_OK};
    d        = digit_of(c);
    prod     = '0;
    sum      = '0;
    limit    = POS_LIMIT;

    if (beat_i.first) begin
      neg   = 1'b0;
      mag   = '0;
      ab    = number_base_i;
      pos_o = OFFSET_BITS'(1);
      if (ab == BASE_BITS'(1) || ab > BASE_BITS'(MAX_BASE)) begin
        emit_o   = 1'b1;
        result_o = '{value: '0, end_offset: '0, status: ST_BAD_BASE};
        ph       = PH_IDLE;
        go       = 1'b0;
      end else begin
        ph = PH_LEAD;
      end
    end else if (ph == PH_IDLE) begin
      go = 1'b0;
    end else begin
      idx   = pos_i;
      pos_o = (pos_i < OFFSET_MAX) ? pos_i + OFFSET_BITS'(1) : OFFSET_MAX;
    end

    if (go && ph == PH_LEAD) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        go = 1'b0;
      end else begin
        ph = PH_START;
        if (c == CH_MINUS) begin
          neg = 1'b1;
          go  = 1'b0;
        end else if (c == CH_PLUS) begin
          go = 1'b0;
        end
      end
    end

    if (go && ph == PH_START) begin
      if (ab == '0) begin
        if (c == CH_ZERO) begin
          ph = PH_ZERO;
          go = 1'b0;
        end else begin
          ab = BASE_BITS'(DEC_BASE);
        end
      end
      if (go) ph = PH_DIGITS;
    end

    if (go && ph == PH_ZERO) begin
      ph  = PH_DIGITS;
      mag = '0;
      if (c == CH_X_LO || c == CH_X_UP) begin
        ab = BASE_BITS'(HEX_BASE);
        go = 1'b0;
      end else begin
        ab = (c >= CH_ONE && c <= CH_SEVEN) ? BASE_BITS'(OCT_BASE) : BASE_BITS'(DEC_BASE);
      end
    end

    if (go) begin
      if (ab < BASE_BITS'(2)) ab = BASE_BITS'(DEC_BASE);
      limit = neg ? NEG_LIMIT : POS_LIMIT;
      // mag * base + d > limit is the same test as mag > (limit - d) / base
      prod  = 70'(mag) * 70'(ab);
      sum   = prod + 70'(d);
      if (ph == PH_DIGITS) begin
        if (d < 7'(ab)) begin
          if (sum > 70'(limit)) begin
            ph = PH_OVF;
          end else begin
            mag = sum[63:0];
          end
        end else begin
          emit_o   = 1'b1;
          result_o = '{value: neg ? (64'd0 - mag) : mag, end_offset: 16'(idx),
                       status: ST_OK};
          ph       = PH_IDLE;
        end
      end else if (ph == PH_OVF) begin
        if (d >= 7'(ab)) begin
          emit_o   = 1'b1;
          result_o = '{value: neg ? NEG_LIMIT : POS_LIMIT, end_offset: 16'(idx),
                       status: ST_RANGE};
          ph       = PH_IDLE;
        end
      end else begin
        ph = PH_IDLE;
      end
    end

    state_o = '{phase: ph, magnitude: mag, negative: neg, active_base: ab};
  end

endmodule

### rtl/string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Streaming strtoll-style converter: one character per beat, one result per
// string with value, end offset and status.
// ----------------------------------------------------------------------------
// Path: the terminating character is held in the input register, stoi_step
//   evaluates it combinationally and the result goes to the output register.
// Throughput: one character per cycle while no blocked result stalls the input,
//   set by the single multiply-by-base and add per character in stoi_step.
// Reset (async, active low): parser idle until a first character, base 0.
module string_to_integer_parser #(
  parameter int OFFSET_BITS = stoi_pkg::OFFSET_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [stoi_pkg::BASE_BITS-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  stoi_pkg::stoi_in_t               in_beat_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output stoi_pkg::stoi_out_t              out_beat_o
);
  import stoi_pkg::*;

  logic [BASE_BITS-1:0]   base_q;
  logic                   in_valid_q;
  stoi_in_t               in_beat_q;
  logic                   out_valid_q;
  stoi_out_t              out_beat_q;
  stoi_state_t            state_q, state_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   emit;
  stoi_out_t              result;
  logic                   out_ready;
  logic                   advance;

  stoi_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .beat_i       (in_beat_q),
    .number_base_i(base_q),
    .state_i      (state_q),
    .pos_i        (pos_q),
    .state_o      (state_d),
    .pos_o        (pos_d),
    .emit_o       (emit),
    .result_o     (result)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_IDLE, magnitude: '0, negative: 1'b0, active_base: '0};
      pos_q       <= '0;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance) begin
        state_q <= state_d;
        pos_q   <= pos_d;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_beat_q <= in_beat_i;
    if (advance && emit) out_beat_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (state_q.phase == PH_IDLE))
    else $error("parser not idle after a result");

  a_range_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.status == ST_RANGE) |->
      (out_beat_o.value == POS_LIMIT || out_beat_o.value == NEG_LIMIT))
    else $error("out-of-range result not saturated");

  a_bad_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_beat_q.first && (base_q == BASE_BITS'(1) ||
      base_q > BASE_BITS'(MAX_BASE))) |=> (out_valid_o && out_beat_o.status == ST_BAD_BASE))
    else $error("invalid base did not report at once");
`endif

endmodule
